FILE: design/ogru_pkg.sv
// Shared types, constants and codes for the occupancy grid ray update unit.
package ogru_pkg;

  // Field and port widths
  localparam int COORD_W    = 12;
  localparam int LO_W       = 16;
  localparam int SUM_W      = LO_W + 1;
  localparam int APB_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  // Default grid dimensions
  localparam int DEF_GRID_X = 32;
  localparam int DEF_GRID_Y = 32;
  localparam int DEF_GRID_Z = 16;

  // Register reset values, signed Q8.8
  localparam logic signed [LO_W-1:0] RST_HIT_INC   = 16'sd217;
  localparam logic signed [LO_W-1:0] RST_MISS_INC  = -16'sd100;
  localparam logic signed [LO_W-1:0] RST_LOWER     = -16'sd507;
  localparam logic signed [LO_W-1:0] RST_UPPER     = 16'sd507;
  localparam logic signed [LO_W-1:0] RST_OCCUPIED  = 16'sd104;

  typedef enum logic [2:0] {
    OP_NEW_SCAN  = 3'd0,
    OP_BEGIN_RAY = 3'd1,
    OP_OBSERVE   = 3'd2,
    OP_END_RAY   = 3'd3,
    OP_CLEAR_MAP = 3'd4,
    OP_QUERY     = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    CS_UNKNOWN  = 2'd0,
    CS_FREE     = 2'd1,
    CS_OCCUPIED = 2'd2
  } cell_status_t;

  typedef enum logic [2:0] {
    REG_HIT_INC  = 3'd0,
    REG_MISS_INC = 3'd1,
    REG_LOWER    = 3'd2,
    REG_UPPER    = 3'd3,
    REG_OCCUPIED = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR_ALL,
    S_IDLE,
    S_ROW,
    S_CELL,
    S_READ,
    S_SUM,
    S_UPDATE,
    S_SWEEP_KNOWN,
    S_SWEEP_MARK,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic [2:0]                opcode;
    logic signed [COORD_W-1:0] cell_x;
    logic signed [COORD_W-1:0] cell_y;
    logic signed [COORD_W-1:0] cell_z;
    logic                      hit_flag;
  } item_t;

  typedef struct packed {
    logic                   accepted;
    logic                   inside_grid;
    logic signed [LO_W-1:0] cell_log_odds;
    logic [1:0]             cell_status;
  } result_t;

  typedef struct packed {
    logic signed [LO_W-1:0] hit_increment;
    logic signed [LO_W-1:0] miss_increment;
    logic signed [LO_W-1:0] lower_clamp;
    logic signed [LO_W-1:0] upper_clamp;
    logic signed [LO_W-1:0] occupied_level;
  } cfg_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic calc_row;
    logic calc_cell;
    logic mem_read;
    logic calc_sum;
    logic update;
    logic sweep_known;
    logic sweep_mark;
    logic load_result;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    op_t  op;
    logic sweep_last;
  } dp_status_t;

endpackage

FILE: design/ogru_chan_if.sv
// Valid/ready channel interface carrying one item of a given payload type.
interface ogru_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: design/ogru_apb_regs.sv
// APB configuration registers for the occupancy grid ray update unit.
module ogru_apb_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ogru_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [ogru_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ogru_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output ogru_pkg::cfg_t                     cfg
);
  import ogru_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes; addresses past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hit_increment  <= RST_HIT_INC;
      cfg.miss_increment <= RST_MISS_INC;
      cfg.lower_clamp    <= RST_LOWER;
      cfg.upper_clamp    <= RST_UPPER;
      cfg.occupied_level <= RST_OCCUPIED;
    end else if (wr_en) begin
      unique case (idx)
        REG_HIT_INC:  cfg.hit_increment  <= pwdata[LO_W-1:0];
        REG_MISS_INC: cfg.miss_increment <= pwdata[LO_W-1:0];
        REG_LOWER:    cfg.lower_clamp    <= pwdata[LO_W-1:0];
        REG_UPPER:    cfg.upper_clamp    <= pwdata[LO_W-1:0];
        REG_OCCUPIED: cfg.occupied_level <= pwdata[LO_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back, sign-extended to the bus width.
  always_comb begin
    unique case (idx)
      REG_HIT_INC:  prdata = APB_DATA_W'(cfg.hit_increment);
      REG_MISS_INC: prdata = APB_DATA_W'(cfg.miss_increment);
      REG_LOWER:    prdata = APB_DATA_W'(cfg.lower_clamp);
      REG_UPPER:    prdata = APB_DATA_W'(cfg.upper_clamp);
      REG_OCCUPIED: prdata = APB_DATA_W'(cfg.occupied_level);
      default:      prdata = '0;
    endcase
  end

endmodule

FILE: design/ogru_ctrl.sv
// Controller state machine that sequences each item through the datapath.
module ogru_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  output logic                   result_valid,
  input  logic                   result_ready,
  input  ogru_pkg::dp_status_t   status,
  output ogru_pkg::ctrl_cmd_t    cmd
);
  import ogru_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        result_valid_next;

  // State and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR_ALL;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      S_CLEAR_ALL: begin
        cmd.sweep_known = 1'b1;
        cmd.sweep_mark  = 1'b1;
        if (status.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_ROW;
        end
      end
      S_ROW: begin
        cmd.calc_row = 1'b1;
        state_next   = S_CELL;
      end
      S_CELL: begin
        cmd.calc_cell = 1'b1;
        state_next    = S_READ;
      end
      S_READ: begin
        cmd.mem_read = 1'b1;
        state_next   = S_SUM;
      end
      S_SUM: begin
        cmd.calc_sum = 1'b1;
        state_next   = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        unique case (status.op)
          OP_CLEAR_MAP: state_next = S_SWEEP_KNOWN;
          OP_NEW_SCAN:  state_next = S_SWEEP_MARK;
          default:      state_next = S_DONE;
        endcase
      end
      S_SWEEP_KNOWN: begin
        cmd.sweep_known = 1'b1;
        if (status.sweep_last) begin
          state_next = S_DONE;
        end
      end
      S_SWEEP_MARK: begin
        cmd.sweep_mark = 1'b1;
        if (status.sweep_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!result_valid || result_ready) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // The output register holds its item until the sink takes it.
  always_comb begin
    if (cmd.load_result) begin
      result_valid_next = 1'b1;
    end else if (result_ready) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> (!result_valid || result_ready))
    else $error("result loaded over an item not yet taken");

  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_DONE)
    else $error("result valid raised outside the done state");

  a_sweep_exit: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SWEEP_KNOWN || state == S_SWEEP_MARK) && status.sweep_last)
      |=> state == S_DONE)
    else $error("bitmap sweep did not finish into the done state");
`endif

endmodule

FILE: design/ogru_datapath.sv
// Datapath: cell addressing, grid memories, log-odds update and result register.
module ogru_datapath #(
  parameter int GRID_X = ogru_pkg::DEF_GRID_X,
  parameter int GRID_Y = ogru_pkg::DEF_GRID_Y,
  parameter int GRID_Z = ogru_pkg::DEF_GRID_Z
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ogru_pkg::cfg_t         cfg,
  input  ogru_pkg::ctrl_cmd_t    cmd,
  output ogru_pkg::dp_status_t   status,
  input  ogru_pkg::item_t        item,
  output ogru_pkg::result_t      result
);
  import ogru_pkg::*;

  localparam int XW         = $clog2(GRID_X);
  localparam int YW         = $clog2(GRID_Y);
  localparam int ZW         = $clog2(GRID_Z);
  localparam int RW         = $clog2(GRID_X * GRID_Y);
  localparam int CELL_COUNT = GRID_X * GRID_Y * GRID_Z;
  localparam int CW         = $clog2(CELL_COUNT);

  // Grid memories
  logic signed [LO_W-1:0] lo_mem    [CELL_COUNT];
  logic                   known_mem [CELL_COUNT];
  logic                   mark_mem  [CELL_COUNT];

  // Captured item
  op_t                    op_q;
  logic signed [COORD_W-1:0] x_q;
  logic signed [COORD_W-1:0] y_q;
  logic signed [COORD_W-1:0] z_q;
  logic                   hit_q;

  // Address stages
  logic                   x_in;
  logic                   y_in;
  logic                   z_in;
  logic                   inside_q;
  logic [RW-1:0]          row_q;
  logic [CW-1:0]          cell_q;

  // Read data and sum stage
  logic signed [LO_W-1:0] lo_rd;
  logic                   known_rd;
  logic                   mark_rd;
  logic signed [LO_W-1:0] base;
  logic signed [LO_W-1:0] inc;
  logic signed [SUM_W-1:0] sum_q;
  logic                   skip_q;

  // Clamp
  logic signed [SUM_W-1:0] sum_lo;
  logic signed [SUM_W-1:0] sum_cl;
  logic signed [LO_W-1:0]  clamped;

  // Ray state
  logic                   ep_valid;
  logic                   ep_valid_next;
  logic [CW-1:0]          ep_cell;
  logic [CW-1:0]          ep_cell_next;
  logic                   last_valid;
  logic                   last_valid_next;
  logic [CW-1:0]          last_cell;
  logic [CW-1:0]          last_cell_next;

  // Step outcome
  logic                   obs_we;
  logic                   mark_set;
  logic                   acc_next;
  logic                   known_next;
  logic signed [LO_W-1:0] lo_next;
  logic                   res_acc;
  logic                   res_inside;
  logic                   res_known;
  logic signed [LO_W-1:0] res_lo;
  logic signed [LO_W-1:0] out_lo;
  cell_status_t           out_status;

  // Memory write ports
  logic                   lo_we;
  logic                   known_we;
  logic                   known_wdata;
  logic [CW-1:0]          known_waddr;
  logic                   mark_we;
  logic                   mark_wdata;
  logic [CW-1:0]          mark_waddr;

  // Sweep counter
  logic [CW-1:0]          sweep_cnt;
  logic                   sweep_last;

  assign sweep_last        = (sweep_cnt == CW'(CELL_COUNT - 1));
  assign status.sweep_last = sweep_last;
  assign status.op         = op_q;

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= op_t'(item.opcode);
      x_q   <= item.cell_x;
      y_q   <= item.cell_y;
      z_q   <= item.cell_z;
      hit_q <= item.hit_flag;
    end
  end

  // Grid bounds checks
  assign x_in = !x_q[COORD_W-1] && (x_q < $signed(COORD_W'(GRID_X)));
  assign y_in = !y_q[COORD_W-1] && (y_q < $signed(COORD_W'(GRID_Y)));
  assign z_in = !z_q[COORD_W-1] && (z_q < $signed(COORD_W'(GRID_Z)));

  // Cell number in two multiply stages: row = x*GRID_Y + y, cell = row*GRID_Z + z.
  always_ff @(posedge clk) begin
    if (cmd.calc_row) begin
      inside_q <= x_in && y_in && z_in;
      row_q    <= RW'(RW'(x_q[XW-1:0]) * RW'(GRID_Y) + RW'(y_q[YW-1:0]));
    end
    if (cmd.calc_cell) begin
      cell_q <= inside_q ? CW'(CW'(row_q) * CW'(GRID_Z) + CW'(z_q[ZW-1:0])) : '0;
    end
  end

  // Registered memory reads
  always_ff @(posedge clk) begin
    if (cmd.mem_read) begin
      lo_rd    <= lo_mem[cell_q];
      known_rd <= known_mem[cell_q];
      mark_rd  <= mark_mem[cell_q];
    end
  end

  // Sum of the stored value and the increment, and the miss skip check
  assign base = known_rd ? lo_rd : '0;
  assign inc  = hit_q ? cfg.hit_increment : cfg.miss_increment;

  always_ff @(posedge clk) begin
    if (cmd.calc_sum) begin
      sum_q  <= SUM_W'(base) + SUM_W'(inc);
      skip_q <= !hit_q && ((ep_valid && (cell_q == ep_cell)) ||
                           (last_valid && (cell_q == last_cell)));
    end
  end

  // Clamp: lower bound first, then upper, so the upper bound wins when crossed.
  always_comb begin
    sum_lo  = (sum_q < SUM_W'(cfg.lower_clamp)) ? SUM_W'(cfg.lower_clamp) : sum_q;
    sum_cl  = (sum_lo > SUM_W'(cfg.upper_clamp)) ? SUM_W'(cfg.upper_clamp) : sum_lo;
    clamped = sum_cl[LO_W-1:0];
  end

  // Per-opcode effect of the step
  always_comb begin
    ep_valid_next   = ep_valid;
    ep_cell_next    = ep_cell;
    last_valid_next = last_valid;
    last_cell_next  = last_cell;
    acc_next        = 1'b1;
    known_next      = known_rd;
    lo_next         = lo_rd;
    obs_we          = 1'b0;
    mark_set        = 1'b0;
    unique case (op_q)
      OP_BEGIN_RAY: begin
        ep_valid_next = hit_q && inside_q;
        if (hit_q && inside_q) begin
          ep_cell_next = cell_q;
        end
        if (hit_q && inside_q && mark_rd) begin
          // A repeated endpoint within the scan rejects the ray.
          ep_valid_next = 1'b0;
          acc_next      = 1'b0;
        end else begin
          mark_set        = hit_q && inside_q;
          last_valid_next = 1'b0;
        end
      end
      OP_OBSERVE: begin
        if (!inside_q || skip_q) begin
          acc_next = 1'b0;
        end else begin
          obs_we          = 1'b1;
          known_next      = 1'b1;
          lo_next         = clamped;
          last_cell_next  = cell_q;
          last_valid_next = 1'b1;
        end
      end
      OP_END_RAY: begin
        ep_valid_next   = 1'b0;
        last_valid_next = 1'b0;
      end
      OP_CLEAR_MAP: begin
        known_next = 1'b0;
      end
      default: ;
    endcase
  end

  // Ray state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ep_valid   <= 1'b0;
      ep_cell    <= '0;
      last_valid <= 1'b0;
      last_cell  <= '0;
    end else if (cmd.update) begin
      ep_valid   <= ep_valid_next;
      ep_cell    <= ep_cell_next;
      last_valid <= last_valid_next;
      last_cell  <= last_cell_next;
    end
  end

  // Step outcome registers
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      res_acc    <= acc_next;
      res_inside <= inside_q;
      res_known  <= known_next;
      res_lo     <= lo_next;
    end
  end

  // Memory write port selection: sweeps clear, updates set.
  always_comb begin
    lo_we       = cmd.update && obs_we;
    known_we    = cmd.sweep_known || lo_we;
    known_wdata = !cmd.sweep_known;
    known_waddr = cmd.sweep_known ? sweep_cnt : cell_q;
    mark_we     = cmd.sweep_mark || (cmd.update && mark_set);
    mark_wdata  = !cmd.sweep_mark;
    mark_waddr  = cmd.sweep_mark ? sweep_cnt : cell_q;
  end

  always_ff @(posedge clk) begin
    if (lo_we) begin
      lo_mem[cell_q] <= clamped;
    end
    if (known_we) begin
      known_mem[known_waddr] <= known_wdata;
    end
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
  end

  // Sweep address counter, one cell per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep_known || cmd.sweep_mark) begin
      sweep_cnt <= sweep_last ? '0 : sweep_cnt + 1'b1;
    end
  end

  // Cell classification against the occupied level
  always_comb begin
    out_lo     = '0;
    out_status = CS_UNKNOWN;
    if (res_inside && res_known) begin
      out_lo     = res_lo;
      out_status = (res_lo >= cfg.occupied_level) ? CS_OCCUPIED : CS_FREE;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      result.accepted      <= res_acc;
      result.inside_grid   <= res_inside;
      result.cell_log_odds <= out_lo;
      result.cell_status   <= out_status;
    end
  end

`ifndef SYNTHESIS
  a_clamp_range: assert property (@(posedge clk) disable iff (rst)
    (lo_we && (cfg.lower_clamp <= cfg.upper_clamp)) |->
      (clamped >= cfg.lower_clamp && clamped <= cfg.upper_clamp))
    else $error("stored log-odds outside the clamp range");

  a_endpoint_source: assert property (@(posedge clk) disable iff (rst)
    $rose(ep_valid) |-> $past(op_q) == OP_BEGIN_RAY)
    else $error("endpoint mark raised by an opcode other than begin_ray");

  a_write_inside: assert property (@(posedge clk) disable iff (rst)
    (cmd.update && (obs_we || mark_set)) |-> inside_q)
    else $error("grid write for a cell outside the grid");
`endif

endmodule

FILE: design/occupancy_grid_ray_update_unit.sv
// An accepted item steps through the row, cell, read, sum, update and done states; its result
// is loaded in the done state once the output register is free, and only then is the next item
// taken. new_scan and clear_map add a pass over every cell of a bitmap, one cell per cycle
// through the bitmap's single write port. Reset is synchronous: after it a clearing pass runs
// during which no item is accepted; configuration writes are taken at any time.
// A finished result waits in the output register while the next item is accepted.
module occupancy_grid_ray_update_unit #(
  parameter int GRID_X = ogru_pkg::DEF_GRID_X,
  parameter int GRID_Y = ogru_pkg::DEF_GRID_Y,
  parameter int GRID_Z = ogru_pkg::DEF_GRID_Z
) (
  input  logic                            clk,
  input  logic                            rst,
  ogru_chan_if.sink                       item_chan,
  ogru_chan_if.source                     result_chan,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ogru_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ogru_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ogru_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import ogru_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;
  item_t      item;
  result_t    result;

  assign item                = item_chan.payload;
  assign result_chan.payload = result;

  // Configuration registers
  ogru_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer
  ogru_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_chan.valid),
    .item_ready   (item_chan.ready),
    .result_valid (result_chan.valid),
    .result_ready (result_chan.ready),
    .status       (status),
    .cmd          (cmd)
  );

  // Grid datapath
  ogru_datapath #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y),
    .GRID_Z (GRID_Z)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .cmd    (cmd),
    .status (status),
    .item   (item),
    .result (result)
  );

endmodule
